// File: design/mwbc_pkg.sv
package mwbc_pkg;

	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_DIRECT = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;

	localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [2:0]  CRC_LAST_BYTE   = 3'd5;

	localparam int ENTRY_W = 40;

	typedef struct packed {
		logic load_item;
		logic idx_clr;
		logic idx_inc;
		logic frame_from_item;
		logic frame_from_ram;
		logic crc_step;
		logic emit;
		logic last;
		logic search_write;
		logic append_write;
		logic cnt_clr;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       cnt_zero;
		logic       cnt_full;
		logic       match;
		logic       idx_last;
		logic       crc_done;
		logic       out_free;
	} status_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: design/mwbc_ram.sv
module mwbc_ram #(
	parameter int W = 40,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/mwbc_datapath.sv
module mwbc_datapath #(
	parameter int BATCH_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mwbc_pkg::cmd_t        cmd,
	output mwbc_pkg::status_t     sts,
	input  logic [1:0]            op,
	input  logic [7:0]            slave_id,
	input  logic [15:0]           reg_addr,
	input  logic [15:0]           value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            frame_slave,
	output logic [7:0]            func_code,
	output logic [15:0]           frame_reg,
	output logic [15:0]           frame_value,
	output logic [15:0]           frame_crc,
	output logic                  last
);

	localparam int IdxW = (BATCH_ENTRIES > 1) ? $clog2(BATCH_ENTRIES) : 1;
	localparam int CntW = $clog2(BATCH_ENTRIES + 1);

	logic [1:0]  it_op_q;
	logic [7:0]  it_slave_q;
	logic [15:0] it_reg_q;
	logic [15:0] it_value_q;

	logic [IdxW-1:0] idx_q;
	logic [CntW-1:0] cnt_q;

	logic [7:0]  fr_slave_q;
	logic [15:0] fr_reg_q;
	logic [15:0] fr_value_q;
	logic [15:0] crc_q;
	logic [2:0]  bcnt_q;
	logic [7:0]  crc_in;

	logic                 out_valid_q;
	logic [7:0]           out_slave_q;
	logic [15:0]          out_reg_q;
	logic [15:0]          out_value_q;
	logic [15:0]          out_crc_q;
	logic                 out_last_q;

	logic                         ram_we;
	logic [IdxW-1:0]              ram_waddr;
	logic [mwbc_pkg::ENTRY_W-1:0] ram_wdata;
	logic [mwbc_pkg::ENTRY_W-1:0] ram_rdata;
	logic [7:0]                   rd_slave;
	logic [15:0]                  rd_reg;
	logic [15:0]                  rd_value;

	mwbc_ram #(
		.W(mwbc_pkg::ENTRY_W),
		.DEPTH(BATCH_ENTRIES)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign rd_slave = ram_rdata[39:32];
	assign rd_reg   = ram_rdata[31:16];
	assign rd_value = ram_rdata[15:0];

	assign ram_we    = cmd.search_write | cmd.append_write;
	assign ram_waddr = cmd.append_write ? cnt_q[IdxW-1:0] : idx_q;
	assign ram_wdata = {it_slave_q, it_reg_q, it_value_q};

	always_comb begin
		case (bcnt_q)
			3'd0:    crc_in = fr_slave_q;
			3'd1:    crc_in = mwbc_pkg::FC_WRITE_SINGLE;
			3'd2:    crc_in = fr_reg_q[15:8];
			3'd3:    crc_in = fr_reg_q[7:0];
			3'd4:    crc_in = fr_value_q[15:8];
			3'd5:    crc_in = fr_value_q[7:0];
			default: crc_in = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			it_op_q    <= op;
			it_slave_q <= slave_id;
			it_reg_q   <= reg_addr;
			it_value_q <= value;
		end
		if (cmd.frame_from_item) begin
			fr_slave_q <= it_slave_q;
			fr_reg_q   <= it_reg_q;
			fr_value_q <= {8'h00, it_value_q[7:0]};
		end else if (cmd.frame_from_ram) begin
			fr_slave_q <= rd_slave;
			fr_reg_q   <= rd_reg;
			fr_value_q <= rd_value;
		end
		if (cmd.frame_from_item || cmd.frame_from_ram) begin
			crc_q <= mwbc_pkg::CRC_INIT;
		end else if (cmd.crc_step) begin
			crc_q <= mwbc_pkg::crc_byte(crc_q, crc_in);
		end
		if (cmd.emit) begin
			out_slave_q <= fr_slave_q;
			out_reg_q   <= fr_reg_q;
			out_value_q <= fr_value_q;
			out_crc_q   <= crc_q;
			out_last_q  <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= '0;
			bcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IdxW'(1);
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.append_write) begin
				cnt_q <= cnt_q + CntW'(1);
			end
			if (cmd.frame_from_item || cmd.frame_from_ram) begin
				bcnt_q <= '0;
			end else if (cmd.crc_step) begin
				bcnt_q <= bcnt_q + 3'd1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.op       = it_op_q;
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.cnt_full = (cnt_q == CntW'(BATCH_ENTRIES));
	assign sts.match    = (rd_slave == it_slave_q) && (rd_reg == it_reg_q);
	assign sts.idx_last = ((CntW'(idx_q) + CntW'(1)) == cnt_q);
	assign sts.crc_done = (bcnt_q == mwbc_pkg::CRC_LAST_BYTE);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign frame_slave = out_slave_q;
	assign func_code   = mwbc_pkg::FC_WRITE_SINGLE;
	assign frame_reg   = out_reg_q;
	assign frame_value = out_value_q;
	assign frame_crc   = out_crc_q;
	assign last        = out_last_q;

endmodule

// File: design/mwbc_ctrl.sv
module mwbc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mwbc_pkg::status_t sts,
	output mwbc_pkg::cmd_t    cmd
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_DECODE = 9'b000000010,
		ST_SRD    = 9'b000000100,
		ST_SCMP   = 9'b000001000,
		ST_APPEND = 9'b000010000,
		ST_FRD    = 9'b000100000,
		ST_FLOAD  = 9'b001000000,
		ST_CRC    = 9'b010000000,
		ST_EMIT   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_item = in_valid;
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (sts.op)
					mwbc_pkg::OP_PUSH: begin
						cmd.idx_clr = 1'b1;
						state_d = sts.cnt_zero ? ST_APPEND : ST_SRD;
					end
					mwbc_pkg::OP_DIRECT: begin
						cmd.frame_from_item = 1'b1;
						state_d = ST_CRC;
					end
					mwbc_pkg::OP_FLUSH: begin
						cmd.idx_clr = 1'b1;
						state_d = sts.cnt_zero ? ST_IDLE : ST_FRD;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_SRD: begin
				state_d = ST_SCMP;
			end
			ST_SCMP: begin
				if (sts.match) begin
					cmd.search_write = 1'b1;
					state_d = ST_IDLE;
				end else if (sts.idx_last) begin
					state_d = ST_APPEND;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = ST_SRD;
				end
			end
			ST_APPEND: begin
				cmd.append_write = !sts.cnt_full;
				state_d = ST_IDLE;
			end
			ST_FRD: begin
				state_d = ST_FLOAD;
			end
			ST_FLOAD: begin
				cmd.frame_from_ram = 1'b1;
				state_d = ST_CRC;
			end
			ST_CRC: begin
				cmd.crc_step = 1'b1;
				if (sts.crc_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = (sts.op != mwbc_pkg::OP_FLUSH) || sts.idx_last;
					if ((sts.op == mwbc_pkg::OP_FLUSH) && !sts.idx_last) begin
						cmd.idx_inc = 1'b1;
						state_d = ST_FRD;
					end else begin
						cmd.cnt_clr = (sts.op == mwbc_pkg::OP_FLUSH);
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// File: design/modbus_write_batch_coalescer.sv
// channel   handshake             payload
// input     in_valid / in_stall   op, slave_id, reg_addr, value
// output    out_valid / out_stall frame_slave, func_code, frame_reg, frame_value, frame_crc, last
//
// one item at a time; push passes decode, then a read and a compare step per held entry compared
// (one ram read each), then an append step when it appends or is dropped
// direct builds and emits one frame; flush emits one frame per held entry; crc runs one byte a cycle
// reset empties the table by clearing the fill count, no clearing pass
// a frame waits in the emit step while the output register is full and stalled
module modbus_write_batch_coalescer #(
	parameter int BATCH_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  slave_id,
	input  logic [15:0] reg_addr,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_slave,
	output logic [7:0]  func_code,
	output logic [15:0] frame_reg,
	output logic [15:0] frame_value,
	output logic [15:0] frame_crc,
	output logic        last
);

	mwbc_pkg::cmd_t    cmd;
	mwbc_pkg::status_t sts;

	mwbc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts(sts),
		.cmd(cmd)
	);

	mwbc_datapath #(
		.BATCH_ENTRIES(BATCH_ENTRIES)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.op(op),
		.slave_id(slave_id),
		.reg_addr(reg_addr),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_slave(frame_slave),
		.func_code(func_code),
		.frame_reg(frame_reg),
		.frame_value(frame_value),
		.frame_crc(frame_crc),
		.last(last)
	);

endmodule

// File: tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TABLE_DEPTH = 16;
	localparam logic [1:0]  OP_PUSH     = mwbc_pkg::OP_PUSH;
	localparam logic [1:0]  OP_DIRECT   = mwbc_pkg::OP_DIRECT;
	localparam logic [1:0]  OP_FLUSH    = mwbc_pkg::OP_FLUSH;
	localparam logic [1:0]  OP_UNUSED   = 2'd3;
	localparam int          PHASE_WORDS = 75;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  slave;
		logic [15:0] reg_addr;
		logic [15:0] data;
	} word_t;

	typedef struct packed {
		logic [7:0]  slave;
		logic [7:0]  func;
		logic [15:0] reg_addr;
		logic [15:0] data;
		logic [15:0] crc;
		logic        last;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = OP_PUSH;
	logic [7:0]  slave_id = 8'h00;
	logic [15:0] reg_addr = 16'h0000;
	logic [15:0] value = 16'h0000;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  frame_slave;
	logic [7:0]  func_code;
	logic [15:0] frame_reg;
	logic [15:0] frame_value;
	logic [15:0] frame_crc;
	logic        last;

	word_t  pending_words[$];
	frame_t expected_frames[$];
	int     errors = 0;
	int     send_gap_pct = 0;
	int     sink_stall_pct = 0;

	// shadow of the write table
	bit          held[TABLE_DEPTH];
	logic [7:0]  held_slave[TABLE_DEPTH];
	logic [15:0] held_reg[TABLE_DEPTH];
	logic [15:0] held_data[TABLE_DEPTH];

	modbus_write_batch_coalescer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.slave_id    (slave_id),
		.reg_addr    (reg_addr),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_slave (frame_slave),
		.func_code   (func_code),
		.frame_reg   (frame_reg),
		.frame_value (frame_value),
		.frame_crc   (frame_crc),
		.last        (last)
	);

	function automatic logic [15:0] modbus_crc(input logic [7:0] s, input logic [15:0] r,
			input logic [15:0] d);
		logic [47:0] bytes;
		logic [15:0] c;
		bytes = {s, mwbc_pkg::FC_WRITE_SINGLE, r, d};
		c = mwbc_pkg::CRC_INIT;
		for (int i = 5; i >= 0; i--) begin
			c = c ^ {8'h00, bytes[i*8 +: 8]};
			for (int b = 0; b < 8; b++) begin
				if (c[0])
					c = (c >> 1) ^ mwbc_pkg::CRC_POLY;
				else
					c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic frame_t build_frame(input logic [7:0] s, input logic [15:0] r,
			input logic [15:0] d, input logic fin);
		frame_t f;
		f.slave    = s;
		f.func     = mwbc_pkg::FC_WRITE_SINGLE;
		f.reg_addr = r;
		f.data     = d;
		f.crc      = modbus_crc(s, r, d);
		f.last     = fin;
		return f;
	endfunction

	task automatic coalesce_word(input word_t w);
		int slot;
		int count;
		int k;
		slot = -1;
		count = 0;
		k = 0;
		case (w.op)
			OP_PUSH: begin
				for (int i = 0; i < TABLE_DEPTH; i++)
					if (slot < 0 && held[i] && held_slave[i] == w.slave &&
							held_reg[i] == w.reg_addr)
						slot = i;
				if (slot < 0)
					for (int i = 0; i < TABLE_DEPTH; i++)
						if (slot < 0 && !held[i])
							slot = i;
				// full table with no match drops the push
				if (slot >= 0) begin
					held[slot]       = 1'b1;
					held_slave[slot] = w.slave;
					held_reg[slot]   = w.reg_addr;
					held_data[slot]  = w.data;
				end
			end
			OP_DIRECT: begin
				expected_frames.push_back(build_frame(w.slave, w.reg_addr,
					{8'h00, w.data[7:0]}, 1'b1));
			end
			OP_FLUSH: begin
				for (int i = 0; i < TABLE_DEPTH; i++)
					if (held[i])
						count++;
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (held[i]) begin
						k++;
						expected_frames.push_back(build_frame(held_slave[i], held_reg[i], held_data[i],
							k == count));
						held[i] = 1'b0;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v, input logic [15:0] got);
		if (exp_v !== got) begin
			$error("%s expected %0h actual %0h", name, exp_v, got);
			errors++;
		end
	endtask

	task automatic add_word(input logic [1:0] o, input logic [7:0] s, input logic [15:0] r,
			input logic [15:0] d);
		word_t w;
		w.op       = o;
		w.slave    = s;
		w.reg_addr = r;
		w.data     = d;
		pending_words.push_back(w);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_frames.size() != 0);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// sender
	always @(posedge clk or negedge arst_n) begin : drive
		word_t w;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			op         <= OP_PUSH;
			slave_id   <= 8'h00;
			reg_addr   <= 16'h0000;
			value      <= 16'h0000;
		end else begin
			if (in_valid && !in_stall) begin
				w.op       = op;
				w.slave    = slave_id;
				w.reg_addr = reg_addr;
				w.data     = value;
				coalesce_word(w);
			end
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					w = pending_words.pop_front();
					in_valid   <= 1'b1;
					op         <= w.op;
					slave_id   <= w.slave;
					reg_addr   <= w.reg_addr;
					value      <= w.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : sink
		frame_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_frames.size() == 0) begin
					$error("unexpected frame slave %0h reg %0h value %0h", frame_slave, frame_reg,
						frame_value);
					errors++;
				end else begin
					e = expected_frames.pop_front();
					check_field("frame_slave", 16'(e.slave), 16'(frame_slave));
					check_field("func_code", 16'(e.func), 16'(func_code));
					check_field("frame_reg", e.reg_addr, frame_reg);
					check_field("frame_value", e.data, frame_value);
					check_field("frame_crc", e.crc, frame_crc);
					check_field("last", 16'(e.last), 16'(last));
				end
			end
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		logic [7:0]  pool_slave[8];
		logic [15:0] pool_reg[8];
		int          produced;
		int          burst;
		int          r;
		int          p;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed words
		add_word(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
		add_word(OP_FLUSH, 8'h00, 16'h0000, 16'h0000);
		add_word(OP_DIRECT, 8'h00, 16'h0000, 16'hFFFF);
		add_word(OP_DIRECT, 8'hFF, 16'hFFFF, 16'hFF00);
		add_word(OP_PUSH, 8'h00, 16'h0000, 16'h0000);
		add_word(OP_PUSH, 8'hFF, 16'hFFFF, 16'hFFFF);
		for (int i = 2; i < TABLE_DEPTH; i++)
			add_word(OP_PUSH, 8'(i), 16'(i * 16'h1111), 16'(i * 16'h0F0F));
		// replace on a full table, then a dropped push
		add_word(OP_PUSH, 8'hFF, 16'hFFFF, 16'h1234);
		add_word(OP_PUSH, 8'h7F, 16'h8000, 16'hA5A5);
		add_word(OP_FLUSH, 8'h55, 16'hAAAA, 16'h5555);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
				1: begin send_gap_pct = 52; sink_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  sink_stall_pct = 52; end
				default: begin send_gap_pct = 23; sink_stall_pct = 23; end
			endcase
			produced = 0;
			while (produced < PHASE_WORDS) begin
				r = $urandom_range(99);
				if (r < 70) begin
					for (int i = 0; i < 8; i++) begin
						pool_slave[i] = 8'($urandom);
						pool_reg[i]   = 16'($urandom);
					end
					burst = $urandom_range(1, 20);
					for (int i = 0; i < burst; i++) begin
						if ($urandom_range(99) < 30) begin
							p = $urandom_range(7);
							add_word(OP_PUSH, pool_slave[p], pool_reg[p], 16'($urandom));
						end else begin
							add_word(OP_PUSH, 8'($urandom), 16'($urandom), 16'($urandom));
						end
						if ($urandom_range(99) < 10) begin
							add_word(OP_DIRECT, 8'($urandom), 16'($urandom), 16'($urandom));
							produced++;
						end
						produced++;
					end
					if ($urandom_range(99) < 90) begin
						add_word(OP_FLUSH, 8'($urandom), 16'($urandom), 16'($urandom));
						produced++;
					end
				end else if (r < 85) begin
					add_word(OP_DIRECT, 8'($urandom), 16'($urandom), 16'($urandom));
					produced++;
				end else if (r < 93) begin
					add_word(OP_FLUSH, 8'($urandom), 16'($urandom), 16'($urandom));
					produced++;
				end else begin
					add_word(OP_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
				end
			end
			// sender holds off until the block has drained
			wait_drained();
		end

		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
